@@ rtl/core/segment_line_intersect_defines.svh @@
// Assertion macros shared by the segment/line intersection RTL.
`ifndef SEGMENT_LINE_INTERSECT_DEFINES_SVH
`define SEGMENT_LINE_INTERSECT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SLI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sli_pkg.sv @@
// Shared constants, types and arithmetic helpers of the intersection block.
`default_nettype none

package sli_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int TOL_W       = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int MOP_W       = COORD_WIDTH + 2;
  localparam int PROD_W      = 2 * MOP_W;
  localparam int WIDE_W      = COORD_WIDTH + 4;
  localparam int DVD_W       = COORD_WIDTH + FRAC_BITS;
  localparam int DIV_LAT     = DVD_W + 1;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic REG_TOLERANCE = 1'b0;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [MOP_W-1:0]       mop_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;
  typedef logic [COORD_WIDTH-1:0]        mag_t;
  typedef logic [DVD_W-1:0]              dvd_t;
  typedef logic [TOL_W-1:0]              tol_t;

  localparam tol_t TOL_RESET = tol_t'(1);

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t px;
    coord_t py;
    coord_t dx;
    coord_t dy;
  } in_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t px;
    coord_t py;
    coord_t dx;
    coord_t dy;
    coord_t m;
    diff_t  sdx;
    diff_t  sdy;
    diff_t  pxa;
    diff_t  apx;
    diff_t  bpx;
    diff_t  pay;
    diff_t  pyb;
    logic   near_dx;
    logic   near_sdx;
    logic   near_den;
  } side_t;

  typedef struct packed {
    logic   hit;
    logic   at_endpoint;
    logic   gen;
    coord_t cross_x;
    coord_t cross_y;
    coord_t py;
  } fin_t;

  typedef struct packed {
    logic   hit;
    logic   at_endpoint;
    coord_t cross_x;
    coord_t cross_y;
  } res_t;

  // True when -t <= v <= t.
  function automatic logic near_f(wide_t v, tol_t t);
    wide_t tw;
    tw = wide_t'(t);
    return (v <= tw) && (v >= -tw);
  endfunction

  // Saturate a wide signed value to the coordinate range.
  function automatic coord_t sat_w(wide_t v);
    logic fits;
    fits = (v[WIDE_W-1:COORD_WIDTH-1] == {(WIDE_W-COORD_WIDTH+1){1'b0}}) ||
           (v[WIDE_W-1:COORD_WIDTH-1] == {(WIDE_W-COORD_WIDTH+1){1'b1}});
    if (fits) begin
      return v[COORD_WIDTH-1:0];
    end
    return v[WIDE_W-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                       : {1'b0, {(COORD_WIDTH-1){1'b1}}};
  endfunction

  // Magnitude of a difference; it always fits in COORD_WIDTH bits.
  function automatic mag_t mag_of(diff_t v);
    logic [DIFF_W-1:0] u;
    u = v;
    if (v[DIFF_W-1]) begin
      u = ~u + {{(DIFF_W-1){1'b0}}, 1'b1};
    end
    return u[COORD_WIDTH-1:0];
  endfunction

  // Drop the fraction of a full product toward zero and saturate.
  function automatic coord_t fix_mul(prod_t p);
    logic              neg;
    logic [PROD_W-1:0] mg;
    logic [PROD_W-1:0] sh;
    logic [PROD_W-1:0] lim;
    logic [COORD_WIDTH-1:0] lo;
    neg = p[PROD_W-1];
    mg  = p;
    if (neg) begin
      mg = ~mg + {{(PROD_W-1){1'b0}}, 1'b1};
    end
    sh  = mg >> FRAC_BITS;
    lim = {{(PROD_W-1){1'b0}}, 1'b1} << (COORD_WIDTH - 1);
    if (!neg) begin
      lim = lim - {{(PROD_W-1){1'b0}}, 1'b1};
    end
    if (sh > lim) begin
      sh = lim;
    end
    lo = sh[COORD_WIDTH-1:0];
    return neg ? (~lo + {{(COORD_WIDTH-1){1'b0}}, 1'b1}) : lo;
  endfunction

  // Saturate a quotient magnitude and apply its sign.
  function automatic coord_t fit_quo(dvd_t q, logic neg);
    logic [DVD_W-1:0]       lim;
    logic [DVD_W-1:0]       mq;
    logic [COORD_WIDTH-1:0] lo;
    lim = {{(DVD_W-1){1'b0}}, 1'b1} << (COORD_WIDTH - 1);
    if (!neg) begin
      lim = lim - {{(DVD_W-1){1'b0}}, 1'b1};
    end
    mq = (q > lim) ? lim : q;
    lo = mq[COORD_WIDTH-1:0];
    return neg ? (~lo + {{(COORD_WIDTH-1){1'b0}}, 1'b1}) : lo;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sli_chan_if.sv @@
// Valid/ready channel interfaces for query and result transactions.
`default_nettype none

interface sli_in_if;
  logic                value_unused_guard;
  logic                valid;
  logic                ready;
  sli_pkg::coord_t     seg_a_x;
  sli_pkg::coord_t     seg_a_y;
  sli_pkg::coord_t     seg_b_x;
  sli_pkg::coord_t     seg_b_y;
  sli_pkg::coord_t     point_x;
  sli_pkg::coord_t     point_y;
  sli_pkg::coord_t     dir_x;
  sli_pkg::coord_t     dir_y;

  modport source (
    output valid, seg_a_x, seg_a_y, seg_b_x, seg_b_y, point_x, point_y, dir_x, dir_y,
    input  ready
  );
  modport sink (
    input  valid, seg_a_x, seg_a_y, seg_b_x, seg_b_y, point_x, point_y, dir_x, dir_y,
    output ready
  );
endinterface

interface sli_out_if;
  logic            valid;
  logic            ready;
  logic            hit;
  logic            at_endpoint;
  sli_pkg::coord_t cross_x;
  sli_pkg::coord_t cross_y;

  modport source (
    output valid, hit, at_endpoint, cross_x, cross_y,
    input  ready
  );
  modport sink (
    input  valid, hit, at_endpoint, cross_x, cross_y,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/segment_line_intersect.sv @@
// Top level of the pipelined segment/line intersection block.
//
// Usage: each transaction on in_ch carries a segment (endpoints a and b) and
// a line (point p, direction d) in signed Q16.16. Exactly one result
// transaction follows on out_ch, in order, with hit, at_endpoint and the
// crossing point (zero on a miss). The tolerance register sits at APB byte
// address 0; write it only while no query is in flight.
// Throughput: one query per cycle while the skid entry is free. The two
// dividers are the long part of the pipe, one quotient bit per stage over
// COORD_WIDTH + FRAC_BITS stages; the multiplies take two stages each.
// Reset clears every valid bit and loads the tolerance with 1; no clearing
// pass is needed, queries are taken from the first cycle after reset.
// Stall: the result register is backed by a one-entry skid register. While
// the receiver stalls, the pipe keeps moving until the skid entry fills,
// and only then does in_ch.ready drop; nothing is lost or repeated.
`default_nettype none
`include "segment_line_intersect_defines.svh"

module segment_line_intersect (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  sli_in_if.sink                                 in_ch,
  sli_out_if.source                              out_ch,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [sli_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [sli_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [sli_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  localparam int DL = sli_pkg::DIV_LAT;

  // Configuration register.
  sli_pkg::tol_t tol_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[sli_pkg::APB_ADDR_W-1] == sli_pkg::REG_TOLERANCE);
  assign prdata = (paddr[sli_pkg::APB_ADDR_W-1] == sli_pkg::REG_TOLERANCE) ?
                  {{(sli_pkg::APB_DATA_W-sli_pkg::TOL_W){1'b0}}, tol_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= sli_pkg::TOL_RESET;
    end else if (cfg_wr) begin
      tol_r <= pwdata[sli_pkg::TOL_W-1:0];
    end
  end

  // Pipeline advance: the whole pipe moves unless the skid entry is full.
  logic en;
  logic skid_v_r;
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // Stage 0: input capture.
  sli_pkg::in_t in0_r;
  logic         v0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      in0_r.ax <= in_ch.seg_a_x;
      in0_r.ay <= in_ch.seg_a_y;
      in0_r.bx <= in_ch.seg_b_x;
      in0_r.by <= in_ch.seg_b_y;
      in0_r.px <= in_ch.point_x;
      in0_r.py <= in_ch.point_y;
      in0_r.dx <= in_ch.dir_x;
      in0_r.dy <= in_ch.dir_y;
    end
  end

  // Stage 1: differences and the vertical tests.
  sli_pkg::side_t side1_nxt, side1_r, side2_r, side3_r, side4_nxt, side4_r;
  logic           v1_r, v2_r, v3_r, v4_r;

  always_comb begin
    side1_nxt          = '0;
    side1_nxt.ax       = in0_r.ax;
    side1_nxt.ay       = in0_r.ay;
    side1_nxt.bx       = in0_r.bx;
    side1_nxt.by       = in0_r.by;
    side1_nxt.px       = in0_r.px;
    side1_nxt.py       = in0_r.py;
    side1_nxt.dx       = in0_r.dx;
    side1_nxt.dy       = in0_r.dy;
    side1_nxt.sdx      = sli_pkg::diff_t'(in0_r.ax) - sli_pkg::diff_t'(in0_r.bx);
    side1_nxt.sdy      = sli_pkg::diff_t'(in0_r.ay) - sli_pkg::diff_t'(in0_r.by);
    side1_nxt.pxa      = sli_pkg::diff_t'(in0_r.px) - sli_pkg::diff_t'(in0_r.ax);
    side1_nxt.apx      = sli_pkg::diff_t'(in0_r.ax) - sli_pkg::diff_t'(in0_r.px);
    side1_nxt.bpx      = sli_pkg::diff_t'(in0_r.bx) - sli_pkg::diff_t'(in0_r.px);
    side1_nxt.pay      = sli_pkg::diff_t'(in0_r.py) - sli_pkg::diff_t'(in0_r.ay);
    side1_nxt.pyb      = sli_pkg::diff_t'(in0_r.py) - sli_pkg::diff_t'(in0_r.by);
    side1_nxt.near_dx  = sli_pkg::near_f(sli_pkg::wide_t'(in0_r.dx), tol_r);
    side1_nxt.near_sdx = sli_pkg::near_f(sli_pkg::wide_t'(side1_nxt.sdx), tol_r);
  end

  // Stages 2-3: the four products of the denominator and the numerator.
  sli_pkg::coord_t fa0, fa1, fa2, fa3;

  sli_mul u_mul_a0 (.clk(clk), .en(en), .a(sli_pkg::mop_t'(side1_r.sdy)),
                    .b(sli_pkg::mop_t'(side1_r.dx)), .p(fa0));
  sli_mul u_mul_a1 (.clk(clk), .en(en), .a(sli_pkg::mop_t'(side1_r.sdx)),
                    .b(sli_pkg::mop_t'(side1_r.dy)), .p(fa1));
  sli_mul u_mul_a2 (.clk(clk), .en(en), .a(sli_pkg::mop_t'(side1_r.dx)),
                    .b(sli_pkg::mop_t'(side1_r.pay)), .p(fa2));
  sli_mul u_mul_a3 (.clk(clk), .en(en), .a(sli_pkg::mop_t'(side1_r.dy)),
                    .b(sli_pkg::mop_t'(side1_r.pxa)), .p(fa3));

  // Stage 4: divider operands. The first divider gives the slope of the
  // line, or the slope of the segment when the direction is vertical.
  sli_pkg::diff_t den_w, num_w, n1_w, d1_w;
  sli_pkg::mag_t  dn1_nxt, dd1_nxt, dn2_nxt, dd2_nxt;
  sli_pkg::mag_t  dn1_r, dd1_r, dn2_r, dd2_r;
  logic           dneg1_nxt, dneg2_nxt, dneg1_r, dneg2_r;

  always_comb begin
    den_w     = sli_pkg::diff_t'(fa0) - sli_pkg::diff_t'(fa1);
    num_w     = sli_pkg::diff_t'(fa2) - sli_pkg::diff_t'(fa3);
    n1_w      = side3_r.near_dx ? side3_r.sdy : sli_pkg::diff_t'(side3_r.dy);
    d1_w      = side3_r.near_dx ? side3_r.sdx : sli_pkg::diff_t'(side3_r.dx);
    dn1_nxt   = sli_pkg::mag_of(n1_w);
    dd1_nxt   = sli_pkg::mag_of(d1_w);
    dneg1_nxt = n1_w[sli_pkg::DIFF_W-1] ^ d1_w[sli_pkg::DIFF_W-1];
    dn2_nxt   = sli_pkg::mag_of(num_w);
    dd2_nxt   = sli_pkg::mag_of(den_w);
    dneg2_nxt = num_w[sli_pkg::DIFF_W-1] ^ den_w[sli_pkg::DIFF_W-1];
    side4_nxt          = side3_r;
    side4_nxt.near_den = sli_pkg::near_f(sli_pkg::wide_t'(den_w), tol_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side1_nxt;
      side2_r <= side1_r;
      side3_r <= side2_r;
      side4_r <= side4_nxt;
      dn1_r   <= dn1_nxt;
      dd1_r   <= dd1_nxt;
      dneg1_r <= dneg1_nxt;
      dn2_r   <= dn2_nxt;
      dd2_r   <= dd2_nxt;
      dneg2_r <= dneg2_nxt;
    end
  end

  // Dividers, with the side data carried alongside.
  sli_pkg::coord_t qm, qc;
  sli_pkg::side_t  sdv_r [DL];
  logic            vdv_r [DL];

  sli_div u_div_m (.clk(clk), .en(en), .num(dn1_r), .den(dd1_r), .neg(dneg1_r), .quo(qm));
  sli_div u_div_c (.clk(clk), .en(en), .num(dn2_r), .den(dd2_r), .neg(dneg2_r), .quo(qc));

  always_ff @(posedge clk) begin
    if (en) begin
      sdv_r[0] <= side4_r;
      for (int k = 1; k < DL; k++) begin
        sdv_r[k] <= sdv_r[k-1];
      end
    end
  end

  // Second multiply group: line height at the endpoints and crossing x.
  sli_pkg::side_t  sd_w, sb1_nxt, sb1_r, sb2_r;
  sli_pkg::coord_t fb0, fb1, fb2;
  logic            vb1_r, vb2_r;

  always_comb begin
    sd_w      = sdv_r[DL-1];
    sb1_nxt   = sd_w;
    sb1_nxt.m = qm;
  end

  sli_mul u_mul_b0 (.clk(clk), .en(en), .a(sli_pkg::mop_t'(qm)),
                    .b(sli_pkg::mop_t'(sd_w.near_dx ? sd_w.pxa : sd_w.apx)), .p(fb0));
  sli_mul u_mul_b1 (.clk(clk), .en(en), .a(sli_pkg::mop_t'(qm)),
                    .b(sli_pkg::mop_t'(sd_w.bpx)), .p(fb1));
  sli_mul u_mul_b2 (.clk(clk), .en(en), .a(sli_pkg::mop_t'(sd_w.sdx)),
                    .b(sli_pkg::mop_t'(qc)), .p(fb2));

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r <= sb1_nxt;
      sb2_r <= sb1_r;
    end
  end

  // Stage 7: all decisions. Only the y of a general crossing is still open.
  sli_pkg::fin_t   fin7_nxt, fin7_r, fin8_r, fin9_r;
  sli_pkg::coord_t m7_r;
  sli_pkg::mop_t   xd7_nxt, xd7_r;
  logic            v7_r, v8_r, v9_r;
  sli_pkg::wide_t  ea, eb, yg, yn, xw, up, lo, ylo, yhi, xlo, xhi, tw;

  always_comb begin
    ea  = sli_pkg::wide_t'(fb0) + sli_pkg::wide_t'(sb2_r.pay);
    eb  = sli_pkg::wide_t'(fb1) + sli_pkg::wide_t'(sb2_r.pyb);
    yg  = sli_pkg::wide_t'(fb0) + sli_pkg::wide_t'(sb2_r.py);
    yn  = sli_pkg::wide_t'(fb0) + sli_pkg::wide_t'(sb2_r.ay);
    xw  = sli_pkg::wide_t'(fb2) + sli_pkg::wide_t'(sb2_r.ax);
    ylo = (sb2_r.ay < sb2_r.by) ? sli_pkg::wide_t'(sb2_r.ay) : sli_pkg::wide_t'(sb2_r.by);
    yhi = (sb2_r.ay < sb2_r.by) ? sli_pkg::wide_t'(sb2_r.by) : sli_pkg::wide_t'(sb2_r.ay);
    xlo = (sb2_r.ax < sb2_r.bx) ? sli_pkg::wide_t'(sb2_r.ax) : sli_pkg::wide_t'(sb2_r.bx);
    xhi = (sb2_r.ax < sb2_r.bx) ? sli_pkg::wide_t'(sb2_r.bx) : sli_pkg::wide_t'(sb2_r.ax);
    tw  = sli_pkg::wide_t'(tol_r);
    up  = yn - yhi;
    lo  = yn - ylo;
    xd7_nxt = sli_pkg::mop_t'(xw - sli_pkg::wide_t'(sb2_r.px));

    fin7_nxt    = '0;
    fin7_nxt.py = sb2_r.py;
    if (sb2_r.near_dx) begin
      // Vertical direction: y of the segment at the line's x.
      if (!sb2_r.near_sdx) begin
        if (sli_pkg::near_f(up, tol_r) || sli_pkg::near_f(lo, tol_r)) begin
          fin7_nxt.hit         = 1'b1;
          fin7_nxt.at_endpoint = 1'b1;
          fin7_nxt.cross_x     = sb2_r.px;
          fin7_nxt.cross_y     = sli_pkg::sat_w(yn);
        end else if (!(up > 0 || lo < 0)) begin
          fin7_nxt.hit     = 1'b1;
          fin7_nxt.cross_x = sb2_r.px;
          fin7_nxt.cross_y = sli_pkg::sat_w(yn);
        end
      end
    end else if (sli_pkg::near_f(ea, tol_r)) begin
      fin7_nxt.hit         = 1'b1;
      fin7_nxt.at_endpoint = 1'b1;
      fin7_nxt.cross_x     = sb2_r.ax;
      fin7_nxt.cross_y     = sb2_r.ay;
    end else if (sli_pkg::near_f(eb, tol_r)) begin
      fin7_nxt.hit         = 1'b1;
      fin7_nxt.at_endpoint = 1'b1;
      fin7_nxt.cross_x     = sb2_r.bx;
      fin7_nxt.cross_y     = sb2_r.by;
    end else if (sb2_r.near_sdx) begin
      // Vertical segment: the line's height at the segment's x.
      if (!(yg > yhi || yg < ylo)) begin
        fin7_nxt.hit     = 1'b1;
        fin7_nxt.cross_x = sb2_r.ax;
        fin7_nxt.cross_y = sli_pkg::sat_w(yg);
      end
    end else if (!sb2_r.near_den) begin
      // General case: strictly inside the x span, with a tolerance margin.
      if (!(xw >= xhi - tw || xw <= xlo + tw)) begin
        fin7_nxt.hit     = 1'b1;
        fin7_nxt.gen     = 1'b1;
        fin7_nxt.cross_x = sli_pkg::sat_w(xw);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin7_r <= fin7_nxt;
      m7_r   <= sb2_r.m;
      xd7_r  <= xd7_nxt;
      fin8_r <= fin7_r;
      fin9_r <= fin8_r;
    end
  end

  // Stages 8-9: y of a general crossing.
  sli_pkg::coord_t fc;

  sli_mul u_mul_c (.clk(clk), .en(en), .a(sli_pkg::mop_t'(m7_r)), .b(xd7_r), .p(fc));

  sli_pkg::res_t res_w;

  always_comb begin
    res_w.hit         = fin9_r.hit;
    res_w.at_endpoint = fin9_r.at_endpoint;
    res_w.cross_x     = fin9_r.cross_x;
    res_w.cross_y     = fin9_r.gen ?
                        sli_pkg::sat_w(sli_pkg::wide_t'(fc) + sli_pkg::wide_t'(fin9_r.py)) :
                        fin9_r.cross_y;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      vb1_r <= 1'b0;
      vb2_r <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      for (int k = 0; k < DL; k++) begin
        vdv_r[k] <= 1'b0;
      end
    end else if (en) begin
      v0_r     <= in_ch.valid;
      v1_r     <= v0_r;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      vdv_r[0] <= v4_r;
      for (int k = 1; k < DL; k++) begin
        vdv_r[k] <= vdv_r[k-1];
      end
      vb1_r <= vdv_r[DL-1];
      vb2_r <= vb1_r;
      v7_r  <= vb2_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
    end
  end

  // Output register with a one-entry skid register behind it.
  sli_pkg::res_t out_r, out_nxt, skid_r, skid_nxt;
  logic          out_v_r, out_v_nxt, skid_v_nxt;
  logic          push, pop;

  assign push = en && v9_r;
  assign pop  = out_v_r && out_ch.ready;

  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = res_w;
        out_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = res_w;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.hit         = out_r.hit;
  assign out_ch.at_endpoint = out_r.at_endpoint;
  assign out_ch.cross_x     = out_r.cross_x;
  assign out_ch.cross_y     = out_r.cross_y;

  // The skid register only ever holds a result behind a waiting one.
  `SLI_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_v_r, "skid entry without output entry")
  // A result arriving at a stalled output must land in the skid register.
  `SLI_ASSERT_NXT(a_stall_fills_skid, out_v_r && !out_ch.ready && push, skid_v_r,
                  "result dropped at stalled output")
  // While the skid register is full the pipe is frozen.
  `SLI_ASSERT_NXT(a_full_skid_freezes, skid_v_r, $stable(v9_r) && $stable(fin9_r),
                  "pipeline moved while skid register was full")

endmodule

`default_nettype wire

@@ rtl/core/sli_mul.sv @@
// Two-stage fixed-point multiplier: full product, then truncate and saturate.
`default_nettype none

module sli_mul (
  input  wire logic          clk,
  input  wire logic          en,
  input  sli_pkg::mop_t      a,
  input  sli_pkg::mop_t      b,
  output sli_pkg::coord_t    p
);

  sli_pkg::prod_t  prod_nxt;
  sli_pkg::prod_t  prod_r;
  sli_pkg::coord_t p_r;

  assign prod_nxt = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      p_r    <= sli_pkg::fix_mul(prod_r);
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

@@ rtl/core/sli_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, saturated result.
`default_nettype none

module sli_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  sli_pkg::mag_t    num,
  input  sli_pkg::mag_t    den,
  input  wire logic        neg,
  output sli_pkg::coord_t  quo
);

  localparam int N = sli_pkg::DVD_W;
  localparam int W = sli_pkg::COORD_WIDTH;

  sli_pkg::mag_t   rem_r [N];
  sli_pkg::dvd_t   q_r   [N];
  sli_pkg::dvd_t   dvd_r [N];
  sli_pkg::mag_t   den_r [N];
  logic            neg_r [N];
  logic            dz_r  [N];
  sli_pkg::coord_t quo_r;

  for (genvar k = 0; k < N; k++) begin : g_stage
    sli_pkg::mag_t rem_in;
    sli_pkg::dvd_t q_in;
    sli_pkg::dvd_t dvd_in;
    sli_pkg::mag_t den_in;
    logic          neg_in;
    logic          dz_in;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;
    sli_pkg::mag_t rem_nxt;
    sli_pkg::dvd_t q_nxt;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign dvd_in = sli_pkg::dvd_t'(num) << sli_pkg::FRAC_BITS;
      assign den_in = den;
      assign neg_in = neg;
      assign dz_in  = (den == '0);
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign dvd_in = dvd_r[k-1];
      assign den_in = den_r[k-1];
      assign neg_in = neg_r[k-1];
      assign dz_in  = dz_r[k-1];
    end

    always_comb begin
      trial   = {rem_in, dvd_in[N-1-k]};
      diff    = trial - {1'b0, den_in};
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
      q_nxt   = {q_in[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        dvd_r[k] <= dvd_in;
        den_r[k] <= den_in;
        neg_r[k] <= neg_in;
        dz_r[k]  <= dz_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= dz_r[N-1] ? '0 : sli_pkg::fit_quo(q_r[N-1], neg_r[N-1]);
    end
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

@@ sim/segment_line_intersect_test.sv @@
// Testbench for the segment/line intersection block: directed and random queries.
`timescale 1ns / 1ps

module segment_line_intersect_test;
  import sli_pkg::*;

  // One query as the sender drives it, and one crossing result as predicted.
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t px;
    coord_t py;
    coord_t dx;
    coord_t dy;
  } query_t;

  typedef struct packed {
    logic   hit;
    logic   at_endpoint;
    coord_t cross_x;
    coord_t cross_y;
  } crossing_t;

  localparam int  PIPE_CYCLES = 80;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  IDLE_PCT    = 35;
  localparam longint SPAN     = longint'(100) <<< FRAC_BITS;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  sli_in_if  query_ch ();
  sli_out_if cross_ch ();

  segment_line_intersect i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (query_ch.sink),
    .out_ch  (cross_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: the tolerance the block holds, and the crossings still owed.
  tol_t      tolerance_now;
  crossing_t crossings_due[$];
  int        error_count;
  int        cycle_count;
  bit        idle_on;
  int        hold_off_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Every mismatch goes through here so that the verdict at the end sees it.
  task automatic report_mismatch(string what);
    error_count++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------
  // Fixed-point arithmetic of the predictor. Products and quotients are
  // formed on 128-bit magnitudes, rounded toward zero and saturated to
  // the 32-bit coordinate range.
  // ---------------------------------------------------------------------
  function automatic logic [127:0] magnitude(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint clamp_signed(logic neg, logic [127:0] m);
    logic [127:0] lim;
    lim = (128'd1 << (COORD_WIDTH - 1)) - (neg ? 128'd0 : 128'd1);
    if (m > lim) begin
      m = lim;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return clamp_signed((a < 0) != (b < 0), (magnitude(a) * magnitude(b)) >> FRAC_BITS);
  endfunction

  function automatic longint q_div(longint a, longint b);
    if (b == 0) begin
      return 0;
    end
    return clamp_signed((a < 0) != (b < 0), (magnitude(a) << FRAC_BITS) / magnitude(b));
  endfunction

  function automatic logic is_near(longint v, longint t);
    return (v <= t) && (v >= -t);
  endfunction

  function automatic coord_t to_coord(longint v);
    longint lim_hi;
    lim_hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    if (v > lim_hi) begin
      v = lim_hi;
    end
    if (v < -lim_hi - 1) begin
      v = -lim_hi - 1;
    end
    return coord_t'(v);
  endfunction

  function automatic crossing_t make_crossing(logic h, logic e, longint x, longint y);
    crossing_t r;
    r.hit         = h;
    r.at_endpoint = e;
    r.cross_x     = to_coord(x);
    r.cross_y     = to_coord(y);
    return r;
  endfunction

  // Where, if anywhere, the line through p along d meets the segment a-b.
  function automatic crossing_t predict_crossing(query_t q, tol_t tol);
    longint ax, ay, bx, by, px, py, dx, dy, t;
    longint sdx, sdy, ylo, yhi, slope, y, upper, lower, den, c, x, xlo, xhi;
    ax = q.ax; ay = q.ay; bx = q.bx; by = q.by;
    px = q.px; py = q.py; dx = q.dx; dy = q.dy;
    t   = longint'(tol);
    sdx = ax - bx;
    sdy = ay - by;
    ylo = (ay < by) ? ay : by;
    yhi = (ay < by) ? by : ay;

    // A vertical direction is handled through the segment's own slope.
    if (is_near(dx, t)) begin
      if (is_near(sdx, t)) begin
        return make_crossing(1'b0, 1'b0, 0, 0);
      end
      y     = q_mul(q_div(sdy, sdx), px - ax) + ay;
      upper = y - yhi;
      lower = y - ylo;
      if (is_near(upper, t) || is_near(lower, t)) begin
        return make_crossing(1'b1, 1'b1, px, y);
      end
      if (upper > 0 || lower < 0) begin
        return make_crossing(1'b0, 1'b0, 0, 0);
      end
      return make_crossing(1'b1, 1'b0, px, y);
    end

    // Otherwise the line passing through either endpoint (a first) wins over the rest.
    slope = q_div(dy, dx);
    if (is_near(q_mul(slope, ax - px) + py - ay, t)) begin
      return make_crossing(1'b1, 1'b1, ax, ay);
    end
    if (is_near(q_mul(slope, bx - px) + py - by, t)) begin
      return make_crossing(1'b1, 1'b1, bx, by);
    end

    if (is_near(sdx, t)) begin
      y = q_mul(slope, ax - px) + py;
      if (y > yhi || y < ylo) begin
        return make_crossing(1'b0, 1'b0, 0, 0);
      end
      return make_crossing(1'b1, 1'b0, ax, y);
    end

    // General case: parallel lines miss, and the crossing must sit strictly
    // inside the x span with a tolerance margin on both sides.
    den = q_mul(sdy, dx) - q_mul(sdx, dy);
    if (is_near(den, t)) begin
      return make_crossing(1'b0, 1'b0, 0, 0);
    end
    c   = q_mul(dx, py - ay) - q_mul(dy, px - ax);
    x   = ax + q_mul(sdx, q_div(c, den));
    xlo = (ax < bx) ? ax : bx;
    xhi = (ax < bx) ? bx : ax;
    if (x >= xhi - t || x <= xlo + t) begin
      return make_crossing(1'b0, 1'b0, 0, 0);
    end
    y = q_mul(slope, x - px) + py;
    return make_crossing(1'b1, 1'b0, x, y);
  endfunction

  // ---------------------------------------------------------------------
  // Query sender. Inputs change only at the falling edge; a transaction is
  // taken at the rising edge where valid and ready are both high. The valid
  // stays high between back-to-back queries, so it is never lowered and
  // raised in one time step.
  // ---------------------------------------------------------------------
  task automatic send_query(query_t q);
    @(negedge clk);
    if (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      query_ch.valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    query_ch.seg_a_x = q.ax;
    query_ch.seg_a_y = q.ay;
    query_ch.seg_b_x = q.bx;
    query_ch.seg_b_y = q.by;
    query_ch.point_x = q.px;
    query_ch.point_y = q.py;
    query_ch.dir_x   = q.dx;
    query_ch.dir_y   = q.dy;
    query_ch.valid   = 1'b1;
    do begin
      @(posedge clk);
    end while (!query_ch.ready);
    crossings_due.push_back(predict_crossing(q, tolerance_now));
  endtask

  task automatic drop_valid();
    @(negedge clk);
    query_ch.valid = 1'b0;
  endtask

  // Block until every owed crossing is back, then let the pipe drain fully.
  task automatic wait_drained();
    drop_valid();
    while (crossings_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // Register write over APB (setup then access), followed by a read-back.
  task automatic write_tolerance(tol_t value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'(4 * REG_TOLERANCE);
    pwdata  = APB_DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    tolerance_now = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    if (prdata[TOL_W-1:0] !== value) begin
      report_mismatch($sformatf("tolerance read %0h, wrote %0h", prdata, value));
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Query shapes. Most random queries are small, and most are built so
  // that the line actually reaches the segment, its endpoints or one of
  // the degenerate branches; the rest are unshaped, some raw 32-bit noise.
  // ---------------------------------------------------------------------
  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t near_coord();
    return coord_t'(longint'($urandom_range(2 * SPAN)) - SPAN);
  endfunction

  function automatic coord_t jitter(coord_t v, int amount);
    return coord_t'(longint'(v) + $urandom_range(2 * amount) - amount);
  endfunction

  function automatic query_t random_query();
    query_t q;
    longint frac;
    q.ax = near_coord(); q.ay = near_coord();
    q.bx = near_coord(); q.by = near_coord();
    q.px = near_coord(); q.py = near_coord();
    q.dx = near_coord(); q.dy = near_coord();
    frac = $urandom_range(256);
    case ($urandom_range(11))
      0, 1: begin
        q = {any_coord(), any_coord(), any_coord(), any_coord(),
             any_coord(), any_coord(), any_coord(), any_coord()};
      end
      2, 3, 4: begin
        // The line runs through a point inside the segment.
        q.px = coord_t'(longint'(q.ax) + (longint'(q.bx) - longint'(q.ax)) * frac / 256);
        q.py = coord_t'(longint'(q.ay) + (longint'(q.by) - longint'(q.ay)) * frac / 256);
      end
      5: begin
        q.bx = jitter(q.ax, 2);
      end
      6: begin
        q.dx = coord_t'($urandom_range(4)) - 2;
        if ($urandom_range(1)) begin
          q.px = coord_t'(longint'(q.ax) + (longint'(q.bx) - longint'(q.ax)) * frac / 256);
        end
      end
      7: begin
        q.px = $urandom_range(1) ? q.ax : q.bx;
        q.py = $urandom_range(1) ? jitter(q.ay, 2) : jitter(q.by, 2);
      end
      8: begin
        // Direction parallel to the segment.
        q.dx = coord_t'((longint'(q.bx) - longint'(q.ax)) / 2);
        q.dy = coord_t'((longint'(q.by) - longint'(q.ay)) / 2);
      end
      9: begin
        q.by = q.ay;
        q.dx = coord_t'($urandom_range(2)) - 1;
      end
      10: begin
        q.dx = jitter('0, 70000);
        q.dy = jitter('0, 70000);
      end
      default: begin
      end
    endcase
    return q;
  endfunction

  task automatic send_random(int count);
    repeat (count) send_query(random_query());
  endtask

  // ---------------------------------------------------------------------
  // Result side: at the falling edge the ready is held low in a long hold-off,
  // else random while idling is on; the checker samples at the rising edge.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left  <= hold_off_left - 1;
      cross_ch.ready <= 1'b0;
    end else begin
      cross_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    crossing_t want;
    if (rst_n && cross_ch.valid && cross_ch.ready) begin
      if (crossings_due.size() == 0) begin
        report_mismatch("crossing result with none outstanding");
      end else begin
        want = crossings_due.pop_front();
        if (cross_ch.hit !== want.hit) begin
          report_mismatch($sformatf("hit %b, want %b", cross_ch.hit, want.hit));
        end
        if (cross_ch.at_endpoint !== want.at_endpoint) begin
          report_mismatch($sformatf("at_endpoint %b, want %b",
                                    cross_ch.at_endpoint, want.at_endpoint));
        end
        if (cross_ch.cross_x !== want.cross_x) begin
          report_mismatch($sformatf("cross_x %h, want %h", cross_ch.cross_x, want.cross_x));
        end
        if (cross_ch.cross_y !== want.cross_y) begin
          report_mismatch($sformatf("cross_y %h, want %h", cross_ch.cross_y, want.cross_y));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("segment_line_intersect_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------

  // Field extremes and every branch: vertical segment, vertical direction,
  // horizontal segment under a vertical direction, endpoint hits at a and
  // b, parallel lines, interior hit, crossing outside the span, saturation.
  task automatic test_directed();
    localparam coord_t ONE  = coord_t'(1 << FRAC_BITS);
    localparam coord_t MAXC = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t MINC = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    send_query('0);
    send_query({MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC});
    send_query({MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC});
    send_query({MINC, MAXC, MAXC, MINC, MAXC, MINC, MINC, MAXC});
    send_query({coord_t'(-1), coord_t'(-1), coord_t'(-1), coord_t'(-1),
                coord_t'(-1), coord_t'(-1), coord_t'(-1), coord_t'(-1)});
    send_query({ONE, 0, ONE, 4 * ONE, 0, 2 * ONE, ONE, 0});
    send_query({ONE, 0, ONE, 4 * ONE, 0, 9 * ONE, ONE, 0});
    send_query({ONE, 0, ONE, 4 * ONE, 0, 0, 0, ONE});
    send_query({0, 0, 4 * ONE, 4 * ONE, 2 * ONE, 0, 0, ONE});
    send_query({0, 0, 4 * ONE, 4 * ONE, 9 * ONE, 0, 0, ONE});
    send_query({0, 2 * ONE, 4 * ONE, 2 * ONE, ONE, 0, 0, ONE});
    send_query({0, 0, 4 * ONE, 4 * ONE, 0, 0, ONE, 2 * ONE});
    send_query({0, 0, 4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, ONE, -ONE});
    send_query({0, 0, 4 * ONE, 4 * ONE, 0, ONE, ONE, ONE});
    send_query({0, 0, 4 * ONE, 4 * ONE, 0, 4 * ONE, ONE, -ONE});
    send_query({0, 0, 4 * ONE, 0, 9 * ONE, ONE, ONE, -ONE});
    send_query({MINC, 0, MAXC, ONE, 0, MAXC, ONE, MINC});
    send_query({0, 0, ONE, ONE, 0, 0, 1, MAXC});
  endtask

  // Tolerance at both extremes and in between, each with a burst of queries.
  task automatic test_tolerance_range();
    tol_t settings[4];
    settings = '{tol_t'(0), tol_t'(16'hFFFF), tol_t'($urandom_range(16'hFFFF)), TOL_RESET};
    foreach (settings[i]) begin
      wait_drained();
      write_tolerance(settings[i]);
      send_random(60);
    end
  endtask

  // The receiver stops for a long stretch while queries keep coming, so the
  // pipe and its skid entry fill and the input must stall.
  task automatic test_backpressure();
    wait_drained();
    hold_off_left = 300;
    send_random(120);
  endtask

  // The sender waits for every result before the next burst.
  task automatic test_pause_and_resume();
    send_random(30);
    wait_drained();
    send_random(30);
  endtask

  // Bulk random traffic: with idling, a stretch of full rate, then more under a new tolerance.
  task automatic test_random_stream();
    send_random(450);
    idle_on = 1'b0;
    send_random(150);
    idle_on = 1'b1;
    wait_drained();
    write_tolerance(tol_t'($urandom_range(64)));
    send_random(100);
  endtask

  initial begin
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    query_ch.valid      = 1'b0;
    query_ch.value_unused_guard = 1'b0;
    {query_ch.seg_a_x, query_ch.seg_a_y, query_ch.seg_b_x, query_ch.seg_b_y,
     query_ch.point_x, query_ch.point_y, query_ch.dir_x, query_ch.dir_y} = '0;
    cross_ch.ready      = 1'b0;
    tolerance_now       = TOL_RESET;
    error_count         = 0;
    cycle_count         = 0;
    idle_on             = 1'b1;
    hold_off_left       = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_tolerance_range();
    test_backpressure();
    test_pause_and_resume();
    test_random_stream();

    wait_drained();
    if (crossings_due.size() != 0) begin
      report_mismatch("crossing results still outstanding");
    end
    if (error_count == 0) begin
      $display("segment_line_intersect_test: clean");
    end else begin
      $display("segment_line_intersect_test: errors");
    end
    $finish;
  end

endmodule
